// ===== design/sphere_box_world_query_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Sphere/box world query assertion macros
// Concurrent assertion shorthands clocked on the rising edge of a given clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPHERE_BOX_WORLD_QUERY_UNIT_ASSERT_SVH
`define SPHERE_BOX_WORLD_QUERY_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define SBWQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbwq assertion failed");

`define SBWQ_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("sbwq assertion failed");

`else

`define SBWQ_ASSERT(lbl, clk, rst_n, prop)

`define SBWQ_ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

// ===== design/sbwq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sphere/box world query package
// Shared item types, codes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sbwq_pkg;

  localparam int unsigned BOXES_DEF    = 16;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned DRAIN_W      = 2;

  localparam logic [15:0]        WALL_TOP_MARGIN_RST    = 16'd80;
  localparam logic [15:0]        GROUND_SNAP_MARGIN_RST = 16'd320;
  localparam logic signed [23:0] NO_GROUND              = -24'sd1600000;
  localparam logic signed [23:0] HEIGHT_MAX             = 24'sh7FFFFF;
  localparam logic signed [23:0] HEIGHT_MIN             = -24'sh800000;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_EMPTY  = 2'd0,
    KIND_GROUND = 2'd1,
    KIND_WALL   = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WALL_TOP_MARGIN    = 1'b0,
    CFG_GROUND_SNAP_MARGIN = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic              cmd;
    logic [3:0]        slot;
    logic [1:0]        kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [22:0]       half_x;
    logic [22:0]       half_y;
    logic [22:0]       half_z;
    logic [19:0]       radius;
  } in_item_t;

  typedef struct packed {
    logic              wall_hit;
    logic              ground_hit;
    logic signed [23:0] ground_height;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    logic [22:0]       ex;
    logic [22:0]       ey;
    logic [22:0]       ez;
  } geo_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic rd_en;
    logic result;
  } ctl_cmd_t;

endpackage

`default_nettype wire

// ===== design/sbwq_in_if.sv =====
// ----------------------------------------------------------------------------
// Sphere/box world query input channel
// Valid/ready channel carrying one load or query item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbwq_in_if;
  logic                valid;
  logic                ready;
  sbwq_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/sbwq_out_if.sv =====
// ----------------------------------------------------------------------------
// Sphere/box world query output channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbwq_out_if;
  logic                valid;
  logic                ready;
  sbwq_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/sbwq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbwq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/sbwq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sphere/box world query controller
// Accepts items, sequences the table scan and hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module sbwq_ctrl #(
  parameter int unsigned BOXES = sbwq_pkg::BOXES_DEF,
  localparam int unsigned AW   = (BOXES > 1) ? $clog2(BOXES) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_is_query_i,
  output logic                    in_ready_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output sbwq_pkg::ctl_cmd_t      cmd_o,
  output logic [AW-1:0]           rd_addr_o
);

  localparam logic [AW-1:0] LAST = AW'(BOXES - 1);
  localparam logic [sbwq_pkg::DRAIN_W-1:0] DRAIN_LAST =
    sbwq_pkg::DRAIN_W'(sbwq_pkg::DRAIN_CYCLES - 1);

  sbwq_pkg::state_e state_q, state_d;
  logic [AW-1:0]                idx_q, idx_d;
  logic [sbwq_pkg::DRAIN_W-1:0] drn_q, drn_d;
  logic                         out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbwq_pkg::ST_IDLE;
      idx_q       <= '0;
      drn_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      drn_q       <= drn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    drn_d      = drn_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    rd_addr_o  = idx_q;
    case (state_q)
      sbwq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_is_query_i == sbwq_pkg::CMD_QUERY) begin
            cmd_o.capture = 1'b1;
            idx_d         = '0;
            state_d       = sbwq_pkg::ST_SCAN;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = sbwq_pkg::ST_RESULT;
          end
        end
      end
      sbwq_pkg::ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (idx_q == LAST) begin
          drn_d   = '0;
          state_d = sbwq_pkg::ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      sbwq_pkg::ST_DRAIN: begin
        if (drn_q == DRAIN_LAST) begin
          state_d = sbwq_pkg::ST_RESULT;
        end else begin
          drn_d = drn_q + 1'b1;
        end
      end
      sbwq_pkg::ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.result = 1'b1;
          state_d      = sbwq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sbwq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/sbwq_dp.sv =====
// ----------------------------------------------------------------------------
// Sphere/box world query datapath
// Box table, four-stage sphere/box test pipeline and result accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module sbwq_dp #(
  parameter int unsigned BOXES = sbwq_pkg::BOXES_DEF,
  localparam int unsigned AW   = (BOXES > 1) ? $clog2(BOXES) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sbwq_pkg::ctl_cmd_t  cmd_i,
  input  wire logic [AW-1:0]       rd_addr_i,
  input  wire sbwq_pkg::in_item_t  item_i,
  input  wire logic [15:0]         wtm_i,
  input  wire logic [15:0]         gsm_i,
  output sbwq_pkg::out_item_t      item_o
);

  localparam int unsigned GW = $bits(sbwq_pkg::geo_t);

  // table write
  logic [8:0]         slot_ext;
  logic               in_range;
  logic               we;
  logic [AW-1:0]      waddr;
  sbwq_pkg::geo_t     wgeo;
  sbwq_pkg::geo_t     rgeo;
  logic [GW-1:0]      rdata;
  logic [BOXES-1:0]   vld_q;

  assign slot_ext = {5'b0, item_i.slot};
  assign in_range = slot_ext < 9'(BOXES);
  assign we       = cmd_i.load && in_range;
  assign waddr    = slot_ext[AW-1:0];

  always_comb begin
    wgeo.kind = item_i.kind;
    wgeo.cx   = item_i.pos_x;
    wgeo.cy   = item_i.pos_y;
    wgeo.cz   = item_i.pos_z;
    wgeo.ex   = item_i.half_x;
    wgeo.ey   = item_i.half_y;
    wgeo.ez   = item_i.half_z;
  end

  sbwq_ram #(
    .WIDTH (GW),
    .DEPTH (BOXES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wgeo),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  assign rgeo = sbwq_pkg::geo_t'(rdata);

  // query registers
  logic signed [23:0] px_q, py_q, pz_q;
  logic [19:0]        r_q;
  logic signed [24:0] foot_q;
  logic signed [25:0] footw_q, footg_q;
  logic [39:0]        r2_q;
  logic               qry_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q   <= item_i.pos_x;
      py_q   <= item_i.pos_y;
      pz_q   <= item_i.pos_z;
      r_q    <= item_i.radius;
      foot_q <= {item_i.pos_y[23], item_i.pos_y} - {5'b0, item_i.radius};
    end
    if (cmd_i.capture || cmd_i.load) begin
      qry_q <= cmd_i.capture;
    end
    footw_q <= {foot_q[24], foot_q} + {10'b0, wtm_i};
    footg_q <= {foot_q[24], foot_q} + {10'b0, gsm_i};
    r2_q    <= {20'b0, r_q} * {20'b0, r_q};
  end

  // stage A: box bounds and top
  logic               s1_vld_q;
  logic signed [24:0] a_lox_q, a_hix_q, a_loy_q, a_hiy_q, a_loz_q, a_hiz_q, a_top_q;
  logic               a_wall_q, a_gnd_q;
  logic               rk_wall, rk_gnd;

  assign rk_wall = s1_vld_q && (rgeo.kind == sbwq_pkg::KIND_WALL);
  assign rk_gnd  = s1_vld_q && ((rgeo.kind == sbwq_pkg::KIND_GROUND) ||
                                (rgeo.kind == sbwq_pkg::KIND_WALL));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      s1_vld_q <= 1'b0;
      a_wall_q <= 1'b0;
      a_gnd_q  <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      s1_vld_q <= cmd_i.rd_en && vld_q[rd_addr_i];
      a_wall_q <= rk_wall;
      a_gnd_q  <= rk_gnd;
    end
  end

  always_ff @(posedge clk_i) begin
    a_lox_q <= {rgeo.cx[23], rgeo.cx} - {2'b0, rgeo.ex};
    a_hix_q <= {rgeo.cx[23], rgeo.cx} + {2'b0, rgeo.ex};
    a_loy_q <= {rgeo.cy[23], rgeo.cy} - {2'b0, rgeo.ey};
    a_hiy_q <= {rgeo.cy[23], rgeo.cy} + {2'b0, rgeo.ey};
    a_loz_q <= {rgeo.cz[23], rgeo.cz} - {2'b0, rgeo.ez};
    a_hiz_q <= {rgeo.cz[23], rgeo.cz} + {2'b0, rgeo.ez};
    a_top_q <= {rgeo.cy[23], rgeo.cy} + {2'b0, rgeo.ey};
  end

  // stage B: distance to clamped point, footprint and standing tests
  logic signed [25:0] dlo_x, dhi_x, dlo_y, dhi_y, dlo_z, dhi_z;
  logic signed [25:0] dx, dy, dz, top_ext;
  logic               fp_x, fp_z, b_wc, b_gc;
  logic signed [25:0] b_dx_q, b_dy_q, b_dz_q;
  logic signed [24:0] b_top_q;
  logic               b_w_q, b_g_q;

  assign dlo_x   = {{2{px_q[23]}}, px_q} - {a_lox_q[24], a_lox_q};
  assign dhi_x   = {{2{px_q[23]}}, px_q} - {a_hix_q[24], a_hix_q};
  assign dlo_y   = {{2{py_q[23]}}, py_q} - {a_loy_q[24], a_loy_q};
  assign dhi_y   = {{2{py_q[23]}}, py_q} - {a_hiy_q[24], a_hiy_q};
  assign dlo_z   = {{2{pz_q[23]}}, pz_q} - {a_loz_q[24], a_loz_q};
  assign dhi_z   = {{2{pz_q[23]}}, pz_q} - {a_hiz_q[24], a_hiz_q};
  assign top_ext = {a_top_q[24], a_top_q};

  always_comb begin
    dx = dlo_x[25] ? dlo_x : ((!dhi_x[25] && dhi_x != '0) ? dhi_x : '0);
    dy = dlo_y[25] ? dlo_y : ((!dhi_y[25] && dhi_y != '0) ? dhi_y : '0);
    dz = dlo_z[25] ? dlo_z : ((!dhi_z[25] && dhi_z != '0) ? dhi_z : '0);
  end

  assign fp_x = !dlo_x[25] && (dhi_x[25] || dhi_x == '0);
  assign fp_z = !dlo_z[25] && (dhi_z[25] || dhi_z == '0);
  assign b_wc = a_wall_q && !(footw_q >= top_ext);
  assign b_gc = a_gnd_q && fp_x && fp_z && (footg_q >= top_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_w_q <= 1'b0;
      b_g_q <= 1'b0;
    end else begin
      b_w_q <= b_wc;
      b_g_q <= b_gc;
    end
  end

  always_ff @(posedge clk_i) begin
    b_dx_q  <= dx;
    b_dy_q  <= dy;
    b_dz_q  <= dz;
    b_top_q <= a_top_q;
  end

  // stage C: squares
  logic [51:0]        sqx, sqy, sqz;
  logic [49:0]        c_sx_q, c_sy_q, c_sz_q;
  logic signed [24:0] c_top_q;
  logic               c_w_q, c_g_q;

  assign sqx = {{26{b_dx_q[25]}}, b_dx_q} * {{26{b_dx_q[25]}}, b_dx_q};
  assign sqy = {{26{b_dy_q[25]}}, b_dy_q} * {{26{b_dy_q[25]}}, b_dy_q};
  assign sqz = {{26{b_dz_q[25]}}, b_dz_q} * {{26{b_dz_q[25]}}, b_dz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_w_q <= 1'b0;
      c_g_q <= 1'b0;
    end else begin
      c_w_q <= b_w_q;
      c_g_q <= b_g_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_sx_q  <= sqx[49:0];
    c_sy_q  <= sqy[49:0];
    c_sz_q  <= sqz[49:0];
    c_top_q <= b_top_q;
  end

  // stage D: compare and accumulate
  logic [51:0]        dist2;
  logic               touch;
  logic               wall_q, hit_q;
  logic signed [24:0] best_q;

  assign dist2 = {2'b0, c_sx_q} + {2'b0, c_sy_q} + {2'b0, c_sz_q};
  assign touch = dist2 <= {12'b0, r2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_q <= 1'b0;
      hit_q  <= 1'b0;
      best_q <= '0;
    end else if (cmd_i.capture) begin
      wall_q <= 1'b0;
      hit_q  <= 1'b0;
      best_q <= '0;
    end else begin
      if (c_w_q && touch) begin
        wall_q <= 1'b1;
      end
      if (c_g_q && (!hit_q || c_top_q > best_q)) begin
        best_q <= c_top_q;
        hit_q  <= 1'b1;
      end
    end
  end

  // result
  logic signed [23:0]  best_sat;
  sbwq_pkg::out_item_t res;
  sbwq_pkg::out_item_t out_q;

  assign best_sat = (best_q[24] != best_q[23]) ?
                    (best_q[24] ? sbwq_pkg::HEIGHT_MIN : sbwq_pkg::HEIGHT_MAX) :
                    best_q[23:0];

  always_comb begin
    res = '0;
    if (qry_q) begin
      res.wall_hit = wall_q;
      if (hit_q) begin
        res.ground_hit    = 1'b1;
        res.ground_height = best_sat;
      end else if (foot_q <= 25'sd0) begin
        res.ground_hit    = 1'b1;
        res.ground_height = '0;
      end else begin
        res.ground_hit    = 1'b0;
        res.ground_height = sbwq_pkg::NO_GROUND;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      out_q <= res;
    end
  end

  assign item_o = out_q;

endmodule

`default_nettype wire

// ===== design/sphere_box_world_query_unit.sv =====
// ----------------------------------------------------------------------------
// Sphere/box world query unit
// Box table with sphere wall-overlap and ground-height queries.
// ----------------------------------------------------------------------------
// A load item writes one box into its slot and yields an all-zero result. A
// query item reads the table one slot per cycle through the single read port
// of the box RAM, feeding a four-stage test pipeline, and the next item is
// taken only once the scan, drain and result states are through for it.
// A finished result sits in an output register and the next item is accepted
// while it waits. The margins are to be written only while the unit is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sphere_box_world_query_unit_assert.svh"

module sphere_box_world_query_unit #(
  parameter int unsigned BOXES = sbwq_pkg::BOXES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  sbwq_in_if.sink                                 in_i,
  sbwq_out_if.source                              out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [sbwq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [sbwq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = (BOXES > 1) ? $clog2(BOXES) : 1;

  logic [15:0]        wtm_q, gsm_q;
  sbwq_pkg::ctl_cmd_t ctl_cmd;
  logic [AW-1:0]      rd_addr;
  logic               in_ready;
  logic               out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wtm_q <= sbwq_pkg::WALL_TOP_MARGIN_RST;
      gsm_q <= sbwq_pkg::GROUND_SNAP_MARGIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sbwq_pkg::CFG_WALL_TOP_MARGIN:    wtm_q <= cfg_data_i;
        sbwq_pkg::CFG_GROUND_SNAP_MARGIN: gsm_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  sbwq_ctrl #(
    .BOXES (BOXES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_is_query_i (in_i.payload.cmd),
    .in_ready_o    (in_ready),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_valid),
    .cmd_o         (ctl_cmd),
    .rd_addr_o     (rd_addr)
  );

  sbwq_dp #(
    .BOXES (BOXES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ctl_cmd),
    .rd_addr_i (rd_addr),
    .item_i    (in_i.payload),
    .wtm_i     (wtm_q),
    .gsm_i     (gsm_q),
    .item_o    (out_o.payload)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  `SBWQ_ASSERT(a_scan_blocks_input, clk_i, rst_ni, ctl_cmd.rd_en |-> !in_i.ready)
  `SBWQ_ASSERT(a_out_from_result, clk_i, rst_ni, $rose(out_o.valid) |-> $past(ctl_cmd.result))
  `SBWQ_ASSERT(a_no_result_clobber, clk_i, rst_ni, ctl_cmd.result |-> (!out_o.valid || out_o.ready))
  `SBWQ_ASSERT_NEVER(a_load_during_scan, clk_i, rst_ni, ctl_cmd.load && ctl_cmd.rd_en)

endmodule

`default_nettype wire
